// ===== hdl/clf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clf_pkg
// Shared types, constants and the pattern scan function of the command line
// character filter.
// ----------------------------------------------------------------------------
package clf_pkg;

    localparam int MAX_LINE   = 512;
    localparam int RD_W       = $clog2(MAX_LINE + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIPE_A,
        CFG_PIPE_B,
        CFG_MULTI_A,
        CFG_MULTI_B
    } clf_cfg_idx_t;

    typedef struct packed {
        logic [7:0] pipe_a;
        logic [7:0] pipe_b;
        logic [7:0] multi_a;
        logic [7:0] multi_b;
    } clf_cfg_t;

    typedef struct packed {
        logic quoted;
        logic pipe_head;
        logic multi_head;
        logic seen;
    } clf_scan_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       line_done;
        logic       status;
        logic       pipe_found;
        logic       more_left;
    } clf_result_t;

    typedef struct packed {
        logic [1:0]  count;
        clf_result_t first;
        clf_result_t second;
    } clf_push_t;

    // pattern scan over one emitted byte
    function automatic clf_scan_t clf_scan_byte(clf_scan_t s, logic [7:0] c,
                                                clf_cfg_t cfg);
        clf_scan_t r;
        r = s;
        if ((s.multi_head && c == cfg.multi_b) || (s.pipe_head && c == cfg.pipe_b))
        begin
            r.seen = 1'b1;
        end
        r.multi_head = 1'b0;
        r.pipe_head  = 1'b0;
        r.quoted     = s.quoted ^ (c == CH_QUOTE);
        if (!r.quoted)
        begin
            if (cfg.multi_a != 8'd0 && c == cfg.multi_a)
            begin
                if (cfg.multi_b == 8'd0)
                    r.seen = 1'b1;
                else
                    r.multi_head = 1'b1;
            end
            if (cfg.pipe_a != 8'd0 && c == cfg.pipe_a)
            begin
                if (cfg.pipe_b == 8'd0)
                    r.seen = 1'b1;
                else
                    r.pipe_head = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic clf_result_t clf_byte_result(logic [7:0] c);
        clf_result_t r;
        r            = '0;
        r.out_byte   = c;
        r.byte_valid = 1'b1;
        r.more_left  = 1'b1;
        return r;
    endfunction

endpackage

// ===== hdl/clf_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clf_ifs
// Valid/ready channels: input characters and line result transactions.
// ----------------------------------------------------------------------------
interface clf_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_end;

    modport source (output valid, in_byte, stream_end, input ready);
    modport sink   (input valid, in_byte, stream_end, output ready);
endinterface

interface clf_line_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       line_done;
    logic       status;
    logic       pipe_found;
    logic       more_left;

    modport source (output valid, out_byte, byte_valid, line_done, status,
                    pipe_found, more_left, input ready);
    modport sink   (input valid, out_byte, byte_valid, line_done, status,
                    pipe_found, more_left, output ready);
endinterface

// ===== hdl/clf_line_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clf_line_ctrl
// Per-character line state: quoting, comments, held continuation plus,
// length limit and pattern scan. Produces zero to two results per transaction.
// ----------------------------------------------------------------------------
module clf_line_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          in_byte,
    input  logic                stream_end,
    input  clf_pkg::clf_cfg_t   cfg,
    output clf_pkg::clf_push_t  push
);
    import clf_pkg::*;

    logic            read_quoted_reg, read_quoted_next;
    logic            in_comment_reg,  in_comment_next;
    logic            held_plus_reg,   held_plus_next;
    logic            last_space_reg,  last_space_next;
    logic            kept_any_reg,    kept_any_next;
    logic [RD_W-1:0] read_count_reg,  read_count_next;
    clf_scan_t       scan_reg,        scan_next;

    logic [RD_W-1:0] rc_inc;
    logic            keep_c;
    logic            ended;
    logic            clear;
    clf_result_t     slot0, slot1;
    logic [1:0]      n;

    always_comb
    begin
        rc_inc           = read_count_reg + 1'b1;
        read_quoted_next = read_quoted_reg;
        in_comment_next  = in_comment_reg;
        held_plus_next   = held_plus_reg;
        last_space_next  = last_space_reg;
        kept_any_next    = kept_any_reg;
        read_count_next  = read_count_reg;
        scan_next        = scan_reg;
        keep_c           = 1'b0;
        ended            = 1'b0;
        clear            = 1'b0;
        slot0            = '0;
        slot1            = '0;
        n                = 2'd0;

        if (take)
        begin
            if (stream_end)
            begin
                if (held_plus_reg)
                begin
                    scan_next = clf_scan_byte(scan_next, CH_PLUS, cfg);
                    slot0     = clf_byte_result(CH_PLUS);
                    slot1.line_done  = 1'b1;
                    slot1.pipe_found = scan_next.seen;
                    n = 2'd2;
                end
                else
                begin
                    slot0.line_done  = 1'b1;
                    slot0.pipe_found = scan_next.seen;
                    n = 2'd1;
                end
                clear = 1'b1;
            end
            else
            begin
                read_count_next  = rc_inc;
                read_quoted_next = read_quoted_reg ^ (in_byte == CH_QUOTE);
                if (!read_quoted_next && in_byte == CH_SEMI && in_byte != cfg.multi_a)
                begin
                    in_comment_next = 1'b1;
                end
                else if (in_byte == CH_NL)
                begin
                    in_comment_next = 1'b0;
                    scan_next       = clf_scan_byte(scan_next, CH_NL, cfg);
                    slot0           = clf_byte_result(CH_NL);
                    n               = 2'd1;
                    last_space_next = 1'b0;
                    if (held_plus_reg)
                    begin
                        held_plus_next = 1'b0;
                    end
                    else
                    begin
                        kept_any_next = 1'b1;
                        ended         = 1'b1;
                    end
                end
                else if (!in_comment_reg)
                begin
                    // plus after a kept space waits for the next character
                    keep_c = !(in_byte == CH_PLUS && kept_any_reg && last_space_reg);
                    held_plus_next = !keep_c;
                    if (held_plus_reg)
                    begin
                        scan_next = clf_scan_byte(scan_next, CH_PLUS, cfg);
                        slot0     = clf_byte_result(CH_PLUS);
                    end
                    if (keep_c)
                    begin
                        scan_next = clf_scan_byte(scan_next, in_byte, cfg);
                        if (held_plus_reg)
                            slot1 = clf_byte_result(in_byte);
                        else
                            slot0 = clf_byte_result(in_byte);
                    end
                    n = {1'b0, held_plus_reg} + {1'b0, keep_c};
                    kept_any_next   = 1'b1;
                    last_space_next = (in_byte == CH_SPACE);
                end

                if (ended)
                begin
                    slot0.line_done  = 1'b1;
                    slot0.pipe_found = scan_next.seen;
                    clear = 1'b1;
                end
                else if (rc_inc >= RD_W'(MAX_LINE))
                begin
                    slot0           = '0;
                    slot0.line_done = 1'b1;
                    slot0.status    = 1'b1;
                    slot0.more_left = 1'b1;
                    slot1           = '0;
                    n               = 2'd1;
                    clear           = 1'b1;
                end
            end
        end

        if (clear)
        begin
            read_quoted_next = 1'b0;
            in_comment_next  = 1'b0;
            held_plus_next   = 1'b0;
            last_space_next  = 1'b0;
            kept_any_next    = 1'b0;
            read_count_next  = '0;
            scan_next        = '0;
        end

        push.count  = n;
        push.first  = slot0;
        push.second = slot1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_quoted_reg <= 1'b0;
            in_comment_reg  <= 1'b0;
            held_plus_reg   <= 1'b0;
            last_space_reg  <= 1'b0;
            kept_any_reg    <= 1'b0;
            read_count_reg  <= '0;
            scan_reg        <= '0;
        end
        else
        begin
            read_quoted_reg <= read_quoted_next;
            in_comment_reg  <= in_comment_next;
            held_plus_reg   <= held_plus_next;
            last_space_reg  <= last_space_next;
            kept_any_reg    <= kept_any_next;
            read_count_reg  <= read_count_next;
            scan_reg        <= scan_next;
        end
    end

endmodule

// ===== hdl/clf_result_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clf_result_fifo
// Result queue: takes up to two results per cycle, hands out one on head_take.
// ----------------------------------------------------------------------------
module clf_result_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  clf_pkg::clf_push_t   push,
    output clf_pkg::clf_result_t head,
    output logic                 head_valid,
    input  logic                 head_take,
    output logic                 room
);
    import clf_pkg::*;

    clf_result_t      mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;

    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign pop        = head_valid && head_take;
    // two free entries needed for the worst-case transaction
    assign room       = (count_reg <= CNT_W'(FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[PTR_W'(wr_ptr_reg + 1'b1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/command_line_char_filter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_char_filter_core
// Assembles a command line from a character stream: quoting, comments,
// continuation plus, length limit and pipe / multi-command pattern detection.
// ----------------------------------------------------------------------------
//  channel   | dir | payload
//  ----------+-----+---------------------------------------------------------
//  char_ch   | in  | in_byte, stream_end
//  line_ch   | out | out_byte, byte_valid, line_done, status, pipe_found,
//            |     | more_left
//  cfg_*     | in  | cfg_we, cfg_index, cfg_data (write only)
//
//  One input transaction per cycle while char_ch.ready is high; its results
//  are in the queue the next cycle. A transaction yields zero to two results;
//  the four-entry queue drains one per cycle while line_ch.ready is high, and
//  char_ch.ready drops while fewer than two entries are free. Reset clears
//  line state, registers and the queue at once.
// ----------------------------------------------------------------------------
module command_line_char_filter_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    clf_char_if.sink                         char_ch,
    clf_line_if.source                       line_ch,
    input  logic                             cfg_we,
    input  logic [clf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [clf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import clf_pkg::*;

    clf_cfg_t    cfg_reg;
    clf_push_t   push;
    clf_result_t head;
    logic        room;
    logic        take;

    assign char_ch.ready = room;
    assign take          = char_ch.valid && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (clf_cfg_idx_t'(cfg_index))
                CFG_PIPE_A:  cfg_reg.pipe_a  <= cfg_data;
                CFG_PIPE_B:  cfg_reg.pipe_b  <= cfg_data;
                CFG_MULTI_A: cfg_reg.multi_a <= cfg_data;
                CFG_MULTI_B: cfg_reg.multi_b <= cfg_data;
                default:     cfg_reg         <= cfg_reg;
            endcase
        end
    end

    clf_line_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .in_byte    (char_ch.in_byte),
        .stream_end (char_ch.stream_end),
        .cfg        (cfg_reg),
        .push       (push)
    );

    clf_result_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .head       (head),
        .head_valid (line_ch.valid),
        .head_take  (line_ch.ready),
        .room       (room)
    );

    assign line_ch.out_byte   = head.out_byte;
    assign line_ch.byte_valid = head.byte_valid;
    assign line_ch.line_done  = head.line_done;
    assign line_ch.status     = head.status;
    assign line_ch.pipe_found = head.pipe_found;
    assign line_ch.more_left  = head.more_left;

endmodule

// ===== test/clf_line_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clf_line_checker
// Watches the character, line and register ports of the command line filter.
// Keeps its own copy of the line state and registers, works out the line
// transactions each accepted character must produce, and compares every
// accepted line transaction field by field against the oldest one expected.
// ----------------------------------------------------------------------------
module clf_line_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    clf_char_if                            char_ch,
    clf_line_if                            line_ch,
    input  logic                           cfg_we,
    input  logic [clf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [clf_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             err_count,
    output int                             pending
);
    import clf_pkg::*;

    clf_cfg_t    cfg;
    clf_result_t line_results [$];
    int          mismatches = 0;

    logic        read_quoted;
    logic        in_comment;
    logic        held_plus;
    logic [7:0]  last_kept;
    logic [9:0]  kept_count;
    int          read_count;
    logic        scan_quoted;
    logic        pipe_head;
    logic        multi_head;
    logic        pattern_seen;

    assign err_count = mismatches;

    function automatic void clear_line();
        read_quoted  = 1'b0;
        in_comment   = 1'b0;
        held_plus    = 1'b0;
        last_kept    = 8'h00;
        kept_count   = '0;
        read_count   = 0;
        scan_quoted  = 1'b0;
        pipe_head    = 1'b0;
        multi_head   = 1'b0;
        pattern_seen = 1'b0;
    endfunction

    function automatic void scan_emitted(logic [7:0] c);
        if (multi_head && c == cfg.multi_b)
            pattern_seen = 1'b1;
        if (pipe_head && c == cfg.pipe_b)
            pattern_seen = 1'b1;
        multi_head = 1'b0;
        pipe_head  = 1'b0;
        if (c == CH_QUOTE)
            scan_quoted = !scan_quoted;
        if (!scan_quoted)
        begin
            if (cfg.multi_a != 8'h00 && c == cfg.multi_a)
            begin
                if (cfg.multi_b == 8'h00)
                    pattern_seen = 1'b1;
                else
                    multi_head = 1'b1;
            end
            if (cfg.pipe_a != 8'h00 && c == cfg.pipe_a)
            begin
                if (cfg.pipe_b == 8'h00)
                    pattern_seen = 1'b1;
                else
                    pipe_head = 1'b1;
            end
        end
    endfunction

    function automatic void push_byte(logic [7:0] c);
        clf_result_t r;
        scan_emitted(c);
        r            = '0;
        r.out_byte   = c;
        r.byte_valid = 1'b1;
        r.more_left  = 1'b1;
        line_results.push_back(r);
    endfunction

    function automatic void push_line_end(logic too_long, logic found, logic more);
        clf_result_t r;
        r            = '0;
        r.line_done  = 1'b1;
        r.status     = too_long;
        r.pipe_found = found;
        r.more_left  = more;
        line_results.push_back(r);
    endfunction

    function automatic void note_kept(logic [7:0] c);
        last_kept = c;
        if (kept_count != 10'h3FF)
            kept_count++;
    endfunction

    function automatic void predict_char(logic [7:0] c, logic eos);
        int          base;
        logic        ended;
        clf_result_t r;
        if (eos)
        begin
            if (held_plus)
                push_byte(CH_PLUS);
            push_line_end(1'b0, pattern_seen, 1'b0);
            clear_line();
            return;
        end
        base  = line_results.size();
        ended = 1'b0;
        read_count++;
        if (c == CH_QUOTE)
            read_quoted = !read_quoted;
        if (!read_quoted && c == CH_SEMI && c != cfg.multi_a)
        begin
            in_comment = 1'b1;
        end
        else if (c == CH_NL)
        begin
            in_comment = 1'b0;
            if (held_plus)
            begin
                held_plus = 1'b0;
                push_byte(CH_NL);
                last_kept = CH_NL;
            end
            else
            begin
                push_byte(CH_NL);
                note_kept(CH_NL);
                ended = 1'b1;
            end
        end
        else if (!in_comment)
        begin
            if (held_plus)
            begin
                held_plus = 1'b0;
                push_byte(CH_PLUS);
            end
            if (c == CH_PLUS && kept_count >= 1 && last_kept == CH_SPACE)
                held_plus = 1'b1;
            else
                push_byte(c);
            note_kept(c);
        end
        if (ended)
        begin
            r            = line_results.pop_back();
            r.line_done  = 1'b1;
            r.pipe_found = pattern_seen;
            r.more_left  = 1'b1;
            line_results.push_back(r);
            clear_line();
        end
        else if (read_count >= MAX_LINE)
        begin
            // overlong line: whatever this character produced is dropped
            while (line_results.size() > base)
                void'(line_results.pop_back());
            push_line_end(1'b1, 1'b0, 1'b1);
            clear_line();
        end
    endfunction

    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            $error("%s: expected %0h, got %0h", field, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        clf_result_t want;
        if (!rst_n)
        begin
            cfg = '0;
            clear_line();
            line_results.delete();
            pending <= 0;
        end
        else
        begin
            if (line_ch.valid && line_ch.ready)
            begin
                if (line_results.size() == 0)
                begin
                    mismatches++;
                    $error("unexpected line transaction: out_byte %0h line_done %0b",
                           line_ch.out_byte, line_ch.line_done);
                end
                else
                begin
                    want = line_results.pop_front();
                    check_field("out_byte", want.out_byte, line_ch.out_byte);
                    check_field("byte_valid", 8'(want.byte_valid), 8'(line_ch.byte_valid));
                    check_field("line_done", 8'(want.line_done), 8'(line_ch.line_done));
                    check_field("status", 8'(want.status), 8'(line_ch.status));
                    check_field("pipe_found", 8'(want.pipe_found), 8'(line_ch.pipe_found));
                    check_field("more_left", 8'(want.more_left), 8'(line_ch.more_left));
                end
            end
            if (char_ch.valid && char_ch.ready)
                predict_char(char_ch.in_byte, char_ch.stream_end);
            if (cfg_we)
            begin
                case (clf_cfg_idx_t'(cfg_index))
                    CFG_PIPE_A:  cfg.pipe_a  = cfg_data;
                    CFG_PIPE_B:  cfg.pipe_b  = cfg_data;
                    CFG_MULTI_A: cfg.multi_a = cfg_data;
                    CFG_MULTI_B: cfg.multi_b = cfg_data;
                    default: ;
                endcase
            end
            pending <= line_results.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the command line filter with a directed set of lines (quoting,
// comments, continuation plus, end of stream, pattern matches), then random
// lines, noise and two maximum-length lines over several register settings,
// with random gaps and back-pressure. Checking is done by clf_line_checker.
// ----------------------------------------------------------------------------
module testbench;
    import clf_pkg::*;

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          PHASE_ITEMS    = 125;
    localparam logic [7:0]  CH_BAR         = 8'h7C;
    localparam logic [7:0]  CH_AMP         = 8'h26;
    localparam logic [7:0]  CH_GT          = 8'h3E;
    localparam logic [7:0]  CH_LOWER_A     = 8'h61;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         cfg_we    = 1'b0;
    clf_cfg_idx_t cfg_index = CFG_PIPE_A;
    logic [7:0]   cfg_data  = 8'h00;
    logic         steady    = 1'b0;
    clf_cfg_t     cfg_now   = '0;
    int           items_sent = 0;
    int           idle_cycles = 0;
    int           err_count;
    int           pending;

    clf_char_if char_ch();
    clf_line_if line_ch();

    command_line_char_filter_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_ch   (char_ch),
        .line_ch   (line_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    clf_line_checker line_check
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_ch   (char_ch),
        .line_ch   (line_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .err_count (err_count),
        .pending   (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        line_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            line_ch.ready <= steady || ($urandom_range(99) >= 12);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (char_ch.valid && char_ch.ready) ||
            (line_ch.valid && line_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(logic [7:0] c, logic eos);
        if (!steady && $urandom_range(99) < 10)
        begin
            char_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        char_ch.valid      <= 1'b1;
        char_ch.in_byte    <= c;
        char_ch.stream_end <= eos;
        do
            @(posedge clk);
        while (!char_ch.ready);
        items_sent++;
    endtask

    task automatic wait_drained();
        char_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(clf_cfg_t c);
        cfg_now = c;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PIPE_A;
        cfg_data  <= c.pipe_a;
        @(posedge clk);
        cfg_index <= CFG_PIPE_B;
        cfg_data  <= c.pipe_b;
        @(posedge clk);
        cfg_index <= CFG_MULTI_A;
        cfg_data  <= c.multi_a;
        @(posedge clk);
        cfg_index <= CFG_MULTI_B;
        cfg_data  <= c.multi_b;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 10) return CH_QUOTE;
        if (r < 18) return CH_SEMI;
        if (r < 28) return CH_SPACE;
        if (r < 36) return CH_PLUS;
        if (r < 41) return CH_NL;
        if (r < 47) return cfg_now.pipe_a;
        if (r < 53) return cfg_now.pipe_b;
        if (r < 59) return cfg_now.multi_a;
        if (r < 65) return cfg_now.multi_b;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] rand_reg();
        case ($urandom_range(7))
            0, 1:    return 8'h00;
            2:       return CH_BAR;
            3:       return CH_AMP;
            4:       return CH_SEMI;
            5:       return CH_GT;
            6:       return CH_QUOTE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_line();
        int n;
        int r;
        n = $urandom_range(16);
        repeat (n)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_item(CH_SPACE, 1'b0);
                send_item(CH_PLUS, 1'b0);
                if ($urandom_range(1) == 1)
                    send_item(CH_NL, 1'b0);
            end
            else
            begin
                send_item(pick_char(), 1'b0);
            end
        end
        r = $urandom_range(99);
        if (r < 80)
            send_item(CH_NL, 1'b0);
        else if (r < 92)
            send_item(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_random_phase();
        int goal;
        goal = items_sent + PHASE_ITEMS;
        while (items_sent < goal)
        begin
            if ($urandom_range(9) == 0)
            begin
                repeat ($urandom_range(1, 8))
                    send_item(8'($urandom_range(255)), $urandom_range(15) == 0);
            end
            else
            begin
                send_line();
            end
        end
    endtask

    // full-length line; without the closing newline it overflows
    task automatic send_long_line(logic close_with_nl);
        logic [7:0] c;
        send_item(8'h00, 1'b1);
        for (int i = 1; i <= MAX_LINE; i++)
        begin
            c = pick_char();
            if (c == CH_NL)
                c = CH_LOWER_A;
            if (i == MAX_LINE && close_with_nl)
                c = CH_NL;
            send_item(c, 1'b0);
        end
    endtask

    initial
    begin
        char_ch.valid      <= 1'b0;
        char_ch.in_byte    <= 8'h00;
        char_ch.stream_end <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        write_config('{pipe_a: CH_BAR, pipe_b: CH_GT, multi_a: CH_AMP, multi_b: 8'h00});
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CH_BAR, 1'b0);
        send_item(CH_GT, 1'b0);
        send_item(CH_NL, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_AMP, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_SEMI, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_SEMI, 1'b0);
        send_item(CH_NL, 1'b0);
        send_item(CH_SPACE, 1'b0);
        send_item(CH_PLUS, 1'b0);
        send_item(CH_NL, 1'b0);
        send_item(CH_SPACE, 1'b0);
        send_item(CH_PLUS, 1'b0);
        send_item(8'h71, 1'b0);
        send_item(CH_SPACE, 1'b0);
        send_item(CH_PLUS, 1'b0);
        send_item(8'hA5, 1'b1);
        send_item(8'h78, 1'b0);
        send_item(CH_BAR, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(CH_AMP, 1'b0);
        send_item(CH_NL, 1'b0);
        wait_drained();

        write_config('0);
        send_random_phase();
        send_long_line(1'b0);
        wait_drained();

        write_config('{pipe_a: CH_BAR, pipe_b: CH_BAR, multi_a: CH_SEMI, multi_b: CH_SEMI});
        send_random_phase();
        wait_drained();

        steady = 1'b1;
        write_config('{pipe_a: 8'hFF, pipe_b: 8'hFF, multi_a: 8'h01, multi_b: 8'hFF});
        send_random_phase();
        wait_drained();
        steady = 1'b0;

        write_config('{pipe_a: rand_reg(), pipe_b: rand_reg(),
                       multi_a: rand_reg(), multi_b: rand_reg()});
        send_random_phase();
        send_long_line(1'b1);
        wait_drained();

        write_config('{pipe_a: rand_reg(), pipe_b: rand_reg(),
                       multi_a: rand_reg(), multi_b: rand_reg()});
        send_random_phase();
        wait_drained();
        repeat (8) @(posedge clk);

        if (err_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
